### src/llve_pkg.sv
// ----------------------------------------------------------------------------
// llve_pkg: shared types and constants of the label value extractor
// Character codes, register indexes, the result bundle passed from the
// front end to the back end, and the byte helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package llve_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  // Configuration port
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 64;
  localparam logic [CfgIdxW-1:0] CFG_LABEL_CHARS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LABEL_LENGTH   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_VALUE_CAPACITY = 2'd2;
  localparam int ResetCapacity = 64;

  // Result queue between front and back end
  localparam int QueueDepth = 4;
  localparam int QPtrW = 2;
  localparam int QCntW = 3;

  // Results caused by one text byte: optional space, optional character,
  // optional done item, emitted in that order
  typedef struct packed {
    logic       has_space;
    logic       has_char;
    logic [7:0] ch;
    logic       has_done;
    logic       found;
  } res_bundle_t;

  // Head of the result queue as seen by the back end
  typedef struct packed {
    logic        valid;
    res_bundle_t bundle;
  } q_head_t;

  function automatic logic [7:0] low_case(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_GAP;
    end
    return c;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

`default_nettype wire

### src/llve_front.sv
// ----------------------------------------------------------------------------
// llve_front: byte classifier and label matcher
// Holds the configuration, scans each text byte for the label at a line
// start, tracks the value phase and pushes the results of each byte as one
// bundle into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module llve_front #(
  parameter int MAX_LABEL    = 8,
  parameter int MAX_CAPACITY = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          text_valid,
  output logic                          text_stall,
  input  logic [7:0]                    text_byte,
  input  logic                          cfg_write,
  input  logic [llve_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [llve_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          full,
  output logic                          push,
  output llve_pkg::res_bundle_t         push_bundle
);
  import llve_pkg::*;

  localparam int LenW = $clog2(MAX_LABEL + 1);
  localparam int LimW = $clog2(MAX_CAPACITY);
  localparam int ResetLim =
    ((ResetCapacity > MAX_CAPACITY) ? MAX_CAPACITY : ResetCapacity) - 1;

  typedef enum logic [4:0] {
    PH_SCAN      = 5'b00001,
    PH_SKIP_PRE  = 5'b00010,
    PH_SKIP_POST = 5'b00100,
    PH_COPY      = 5'b01000,
    PH_DRAIN     = 5'b10000
  } phase_t;

  // Configuration (label held lowercased)
  logic [MAX_LABEL-1:0][7:0] label_lc;
  logic [LenW-1:0]           label_size;
  logic [LimW-1:0]           raw_limit;
  logic [LenW-1:0]           len_sat;
  logic [LimW-1:0]           lim_sat;

  // Scan state
  phase_t                    phase, phase_next;
  logic                      at_line_start, at_line_start_next;
  logic [LimW-1:0]           raw_count, raw_count_next;
  logic                      pending_space, pending_space_next;
  logic                      emitted_any, emitted_any_next;
  logic [MAX_LABEL-1:0][7:0] hist_byte, hist_byte_next;
  logic [MAX_LABEL-1:0]      hist_ls, hist_ls_next;

  logic [MAX_LABEL-1:0][7:0] shift_byte;
  logic [MAX_LABEL-1:0]      shift_ls;
  logic [MAX_LABEL:0]        match_len;
  logic                      label_match;
  logic                      accept;
  logic                      do_copy;
  logic                      do_restart;
  logic [LimW-1:0]           raw_inc;
  res_bundle_t               bundle;

  assign accept     = text_valid && !full;
  assign text_stall = full;

  // Saturate configuration values as they are written
  always_comb begin
    logic [31:0] cap32;
    cap32 = 32'(cfg_data[8:0]);
    if (cfg_data[3:0] > 4'(MAX_LABEL)) begin
      len_sat = LenW'(MAX_LABEL);
    end else begin
      len_sat = LenW'(cfg_data[3:0]);
    end
    if (cap32 > 32'(MAX_CAPACITY)) begin
      lim_sat = LimW'(MAX_CAPACITY - 1);
    end else if (cap32 == 32'd0) begin
      lim_sat = '0;
    end else begin
      lim_sat = LimW'(cap32 - 32'd1);
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      label_lc   <= '0;
      label_size <= '0;
      raw_limit  <= LimW'(ResetLim);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LABEL_CHARS: begin
          for (int i = 0; i < MAX_LABEL; i++) begin
            label_lc[i] <= low_case(cfg_data[8*i +: 8]);
          end
        end
        CFG_LABEL_LENGTH:   label_size <= len_sat;
        CFG_VALUE_CAPACITY: raw_limit <= lim_sat;
        default: ;
      endcase
    end
  end

  // Shift the byte into the history
  always_comb begin
    shift_byte[0] = low_case(text_byte);
    shift_ls[0]   = at_line_start;
    for (int k = 1; k < MAX_LABEL; k++) begin
      shift_byte[k] = hist_byte[k-1];
      shift_ls[k]   = hist_ls[k-1];
    end
  end

  // Compare the shifted history with the label, once for each length
  always_comb begin
    logic m;
    match_len[0] = 1'b0;
    for (int l = 1; l <= MAX_LABEL; l++) begin
      m = shift_ls[l-1];
      for (int i = 0; i < MAX_LABEL; i++) begin
        if (i < l) begin
          if (shift_byte[l-1-i] != label_lc[i]) begin
            m = 1'b0;
          end
        end
      end
      match_len[l] = m;
    end
  end

  assign label_match = match_len[label_size];

  // Next state and results of one byte
  always_comb begin
    phase_next         = phase;
    at_line_start_next = at_line_start;
    raw_count_next     = raw_count;
    pending_space_next = pending_space;
    emitted_any_next   = emitted_any;
    hist_byte_next     = hist_byte;
    hist_ls_next       = hist_ls;
    bundle             = '0;
    do_copy            = 1'b0;
    do_restart         = 1'b0;
    raw_inc            = raw_count + LimW'(1);

    case (phase)
      PH_SCAN: begin
        if (text_byte == CH_NUL) begin
          bundle.has_done = 1'b1;
          do_restart      = 1'b1;
        end else begin
          hist_byte_next     = shift_byte;
          hist_ls_next       = shift_ls;
          at_line_start_next = (text_byte == CH_LF) || (text_byte == CH_CR);
          if (label_match) begin
            phase_next = PH_SKIP_PRE;
          end
        end
      end
      PH_SKIP_PRE, PH_SKIP_POST: begin
        if (text_byte == CH_NUL) begin
          bundle.has_done = 1'b1;
          do_restart      = 1'b1;
        end else if (is_ws(text_byte)) begin
          phase_next = phase;
        end else if (phase == PH_SKIP_PRE && text_byte == CH_COLON) begin
          phase_next = PH_SKIP_POST;
        end else begin
          do_copy = 1'b1;
        end
      end
      PH_COPY: do_copy = 1'b1;
      PH_DRAIN: begin
        if (text_byte == CH_NUL) begin
          do_restart = 1'b1;
        end
      end
      default: do_restart = 1'b1;
    endcase

    // Copy one byte of the value line
    if (do_copy) begin
      if (text_byte == CH_NUL || text_byte == CH_LF || text_byte == CH_CR ||
          raw_count >= raw_limit) begin
        bundle.has_done = 1'b1;
        bundle.found    = emitted_any;
        if (text_byte == CH_NUL) begin
          do_restart = 1'b1;
        end else begin
          phase_next = PH_DRAIN;
        end
      end else begin
        phase_next     = PH_COPY;
        raw_count_next = raw_inc;
        if (is_ws(text_byte)) begin
          if (emitted_any) begin
            pending_space_next = 1'b1;
          end
        end else begin
          bundle.has_space   = pending_space;
          bundle.has_char    = 1'b1;
          bundle.ch          = low_case(text_byte);
          pending_space_next = 1'b0;
          emitted_any_next   = 1'b1;
        end
        if (raw_inc >= raw_limit) begin
          bundle.has_done = 1'b1;
          bundle.found    = emitted_any_next;
          phase_next      = PH_DRAIN;
        end
      end
    end

    // Restart the scan for the next text
    if (do_restart) begin
      phase_next         = PH_SCAN;
      at_line_start_next = 1'b1;
      raw_count_next     = '0;
      pending_space_next = 1'b0;
      emitted_any_next   = 1'b0;
      hist_ls_next       = '0;
    end
  end

  assign push        = accept && (bundle.has_space || bundle.has_char || bundle.has_done);
  assign push_bundle = bundle;

  // Advance control state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SCAN;
      at_line_start <= 1'b1;
      raw_count     <= '0;
      pending_space <= 1'b0;
      emitted_any   <= 1'b0;
      hist_ls       <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      at_line_start <= at_line_start_next;
      raw_count     <= raw_count_next;
      pending_space <= pending_space_next;
      emitted_any   <= emitted_any_next;
      hist_ls       <= hist_ls_next;
    end
  end

  // Hold history bytes; unused slots are masked by their line-start flags
  always_ff @(posedge clk) begin
    if (accept) begin
      hist_byte <= hist_byte_next;
    end
  end

`ifndef SYNTHESIS
  a_push_needs_item: assert property (@(posedge clk) disable iff (rst)
    push |-> text_valid && !text_stall)
    else $error("result pushed without an accepted item");
  a_space_after_char: assert property (@(posedge clk) disable iff (rst)
    pending_space |-> emitted_any)
    else $error("pending space before any value character");
  a_raw_only_in_value: assert property (@(posedge clk) disable iff (rst)
    (raw_count != '0) |-> (phase == PH_COPY || phase == PH_DRAIN))
    else $error("raw count set outside the value line");
`endif

endmodule

`default_nettype wire

### src/llve_fifo.sv
// ----------------------------------------------------------------------------
// llve_fifo: result bundle queue
// Four-entry queue between the front end and the back end, so that either
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module llve_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  llve_pkg::res_bundle_t push_bundle,
  output logic                  full,
  output llve_pkg::q_head_t     head,
  input  logic                  pop
);
  import llve_pkg::*;

  res_bundle_t        entries [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCntW-1:0]   count;

  assign full        = (count == QCntW'(QueueDepth));
  assign head.valid  = (count != '0);
  assign head.bundle = entries[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCntW'(1);
        2'b01:   count <= count - QCntW'(1);
        default: count <= count;
      endcase
    end
  end

  // Store pushed bundles
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_bundle;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QueueDepth))
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

### src/llve_back.sv
// ----------------------------------------------------------------------------
// llve_back: result sequencer
// Unpacks the bundle at the head of the queue into single result items and
// drives them through the output register, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module llve_back (
  input  logic              clk,
  input  logic              rst,
  input  llve_pkg::q_head_t head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [7:0]        out_byte,
  output logic              value_done,
  output logic              found
);
  import llve_pkg::*;

  // Parts of the head bundle already sent: {done, char, space}
  logic [2:0] used;
  logic [2:0] mark;
  logic       rem_space, rem_char, rem_done;
  logic       last;
  logic       load;
  logic       advance;
  logic [7:0] pick_byte;
  logic       pick_done;
  logic       pick_found;

  assign rem_space = head.bundle.has_space && !used[0];
  assign rem_char  = head.bundle.has_char  && !used[1];
  assign rem_done  = head.bundle.has_done  && !used[2];
  assign load      = !result_valid || !result_stall;
  assign advance   = load && head.valid;
  assign pop       = advance && last;

  // Pick the next part of the head bundle
  always_comb begin
    pick_byte  = CH_NUL;
    pick_done  = 1'b0;
    pick_found = 1'b0;
    mark       = 3'b000;
    last       = 1'b1;
    if (rem_space) begin
      pick_byte = CH_SPACE;
      mark      = 3'b001;
      last      = !rem_char && !rem_done;
    end else if (rem_char) begin
      pick_byte = head.bundle.ch;
      mark      = 3'b010;
      last      = !rem_done;
    end else begin
      pick_done  = 1'b1;
      pick_found = head.bundle.found;
      mark       = 3'b100;
    end
  end

  // Advance output valid and bundle progress
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      used         <= 3'b000;
    end else if (load) begin
      result_valid <= head.valid;
      if (head.valid) begin
        if (last) begin
          used <= 3'b000;
        end else begin
          used <= used | mark;
        end
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= pick_byte;
      value_done <= pick_done;
      found      <= pick_found;
    end
  end

`ifndef SYNTHESIS
  a_found_only_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && !value_done |-> !found)
    else $error("found flag on a value item");
  a_done_byte_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && value_done |-> out_byte == CH_NUL)
    else $error("done item with a non-zero byte");
  a_partial_has_head: assert property (@(posedge clk) disable iff (rst)
    (used != 3'b000) |-> head.valid)
    else $error("bundle partly sent but queue empty");
`endif

endmodule

`default_nettype wire

### src/line_label_value_extractor_top.sv
// ----------------------------------------------------------------------------
// line_label_value_extractor_top: labelled line value extractor
// Throughput: one text byte per cycle; results leave one per cycle while
// result_stall is low, and the input stalls while the four-bundle result
// queue is full. Each result passes the result queue and the output register.
// Reset: synchronous; registers return to their reset values, no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module line_label_value_extractor_top #(
  parameter int MAX_LABEL    = 8,
  parameter int MAX_CAPACITY = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          text_valid,
  output logic                          text_stall,
  input  logic [7:0]                    text_byte,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [7:0]                    out_byte,
  output logic                          value_done,
  output logic                          found,
  input  logic                          cfg_write,
  input  logic [llve_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [llve_pkg::CfgDataW-1:0] cfg_data
);
  import llve_pkg::*;

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  res_bundle_t q_push_bundle;
  q_head_t     q_head;

  // Classify bytes and match the label
  llve_front #(
    .MAX_LABEL    (MAX_LABEL),
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_byte   (text_byte),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .full        (q_full),
    .push        (q_push),
    .push_bundle (q_push_bundle)
  );

  // Decouple front and back end
  llve_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (q_push),
    .push_bundle (q_push_bundle),
    .full        (q_full),
    .head        (q_head),
    .pop         (q_pop)
  );

  // Send result items
  llve_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .value_done   (value_done),
    .found        (found)
  );

endmodule

`default_nettype wire

### sim/line_label_value_extractor_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_label_value_extractor_top_test: self-checking bench of the extractor
// Streams zero-terminated texts into the block, one byte per item, and checks
// every value byte and done item against an in-bench model of the label search
// or a typed table row's value. A short table of hand-picked texts comes first,
// then random texts mostly on the configured label. Both sides idle at random.
// ----------------------------------------------------------------------------
module line_label_value_extractor_top_test;
  import llve_pkg::*;

  localparam int LABEL_MAX = 8;
  localparam int CAP_MAX = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES = 220;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  typedef enum logic [2:0] {
    LOOK_FOR_LABEL,
    SKIP_BEFORE_COLON,
    SKIP_AFTER_COLON,
    COPY_VALUE,
    IGNORE_TO_END
  } scan_state_t;

  typedef enum int {STALL_NONE, STALL_THIRD, STALL_RANDOM, STALL_HEAVY} stall_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_done;
    logic       is_found;
  } value_item_t;

  typedef struct {
    bit    set_regs;
    string label;
    int    len;
    int    cap;
    string text;
    bit    typed;
    string value;
    bit    hit;
  } text_case_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                text_valid = 1'b0;
  logic                text_stall;
  logic [7:0]          text_byte = 8'h00;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [7:0]          out_byte;
  logic                value_done;
  logic                found;
  logic                cfg_write = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_LABEL_CHARS;
  logic [CfgDataW-1:0] cfg_data = '0;

  line_label_value_extractor_top dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .value_done   (value_done),
    .found        (found),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Model copy of the registers and of the scan state
  logic [63:0] lbl_chars;
  logic [3:0]  lbl_len;
  logic [8:0]  val_cap;
  scan_state_t scan_state;
  bit          line_begin;
  int          raw_cnt;
  bit          space_due;
  bit          have_output;
  logic [7:0]  recent_bytes [LABEL_MAX];
  bit          recent_ls [LABEL_MAX];
  int          recent_fill;

  value_item_t predicted_values[$];
  bit          table_mode = 1'b0;

  // Bench bookkeeping
  int errors = 0;
  int bytes_in = 0;
  int results_checked = 0;
  int values_found = 0;
  int values_empty = 0;
  int texts_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_left = 0;
  int stall_tick = 0;
  logic [63:0] gen_label = '0;
  int gen_len = 0;
  logic [7:0] text_buf[$];
  text_case_t text_cases[$];

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_GAP : c;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int raw_limit();
    int cap;
    cap = val_cap;
    if (cap > CAP_MAX) cap = CAP_MAX;
    if (cap == 0) cap = 1;
    return cap - 1;
  endfunction

  task automatic restart_text();
    scan_state = LOOK_FOR_LABEL;
    line_begin = 1'b1;
    raw_cnt = 0;
    space_due = 1'b0;
    have_output = 1'b0;
    recent_fill = 0;
    for (int i = 0; i < LABEL_MAX; i++) begin
      recent_bytes[i] = 8'h00;
      recent_ls[i] = 1'b0;
    end
  endtask

  // Typed table rows carry their own expectation, so hold the model's back
  task automatic note_result(input logic [7:0] ch, input bit fin, input bit hit);
    if (!table_mode) predicted_values.push_back('{ch: ch, is_done: fin, is_found: hit});
  endtask

  // Shift the byte into the history; report a label ending here at a line start
  function automatic bit label_hit(input logic [7:0] b);
    int span;
    bit ok;
    span = (lbl_len > LABEL_MAX) ? LABEL_MAX : int'(lbl_len);
    for (int i = LABEL_MAX - 1; i > 0; i--) begin
      recent_bytes[i] = recent_bytes[i-1];
      recent_ls[i] = recent_ls[i-1];
    end
    recent_bytes[0] = b;
    recent_ls[0] = line_begin;
    if (recent_fill < LABEL_MAX) recent_fill++;
    line_begin = (b == CH_LF || b == CH_CR);
    if (span == 0 || recent_fill < span || !recent_ls[span-1]) return 1'b0;
    ok = 1'b1;
    for (int i = 0; i < span; i++) begin
      if (fold_case(recent_bytes[span-1-i]) != fold_case(lbl_chars[8*i +: 8])) ok = 1'b0;
    end
    return ok;
  endfunction

  // One byte of the value line
  task automatic copy_value_byte(input logic [7:0] b);
    int lim;
    lim = raw_limit();
    if (b == CH_NUL || b == CH_LF || b == CH_CR || raw_cnt >= lim) begin
      note_result(CH_NUL, 1'b1, have_output);
      if (b == CH_NUL) restart_text();
      else scan_state = IGNORE_TO_END;
      return;
    end
    scan_state = COPY_VALUE;
    raw_cnt++;
    if (is_blank(b)) begin
      if (have_output) space_due = 1'b1;
    end else begin
      if (space_due) note_result(CH_SPACE, 1'b0, 1'b0);
      note_result(fold_case(b), 1'b0, 1'b0);
      space_due = 1'b0;
      have_output = 1'b1;
    end
    // Limit reached: the pending space, if any, is dropped
    if (raw_cnt >= lim) begin
      note_result(CH_NUL, 1'b1, have_output);
      scan_state = IGNORE_TO_END;
    end
  endtask

  task automatic extract_step(input logic [7:0] b);
    case (scan_state)
      LOOK_FOR_LABEL: begin
        if (b == CH_NUL) begin
          note_result(CH_NUL, 1'b1, 1'b0);
          restart_text();
        end else if (label_hit(b)) begin
          scan_state = SKIP_BEFORE_COLON;
        end
      end
      SKIP_BEFORE_COLON, SKIP_AFTER_COLON: begin
        if (b == CH_NUL) begin
          note_result(CH_NUL, 1'b1, 1'b0);
          restart_text();
        end else if (is_blank(b)) begin
          // whitespace may cross lines here
        end else if (scan_state == SKIP_BEFORE_COLON && b == CH_COLON) begin
          scan_state = SKIP_AFTER_COLON;
        end else begin
          copy_value_byte(b);
        end
      end
      COPY_VALUE: copy_value_byte(b);
      default: begin
        if (b == CH_NUL) restart_text();
      end
    endcase
  endtask

  task automatic check_result();
    value_item_t exp;
    results_checked++;
    if (value_done) begin
      if (found) values_found++;
      else values_empty++;
    end
    if (predicted_values.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected: out_byte %h value_done %b found %b",
               $time, out_byte, value_done, found);
      return;
    end
    exp = predicted_values.pop_front();
    if (out_byte !== exp.ch) begin
      errors++;
      $display("%0t: out_byte expected %h actual %h", $time, exp.ch, out_byte);
    end
    if (value_done !== exp.is_done) begin
      errors++;
      $display("%0t: value_done expected %b actual %b", $time, exp.is_done, value_done);
    end
    if (found !== exp.is_found) begin
      errors++;
      $display("%0t: found expected %b actual %b", $time, exp.is_found, found);
    end
  endtask

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      lbl_chars = '0;
      lbl_len = '0;
      val_cap = 9'(ResetCapacity);
      restart_text();
      idle_cycles = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_LABEL_CHARS:    lbl_chars = cfg_data;
          CFG_LABEL_LENGTH:   lbl_len = cfg_data[3:0];
          CFG_VALUE_CAPACITY: val_cap = cfg_data[8:0];
          default: ;
        endcase
      end
      if (text_valid && !text_stall) begin
        bytes_in++;
        extract_step(text_byte);
      end
      if (result_valid && !result_stall) check_result();
      if (cfg_write || (text_valid && !text_stall) || (result_valid && !result_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver stalls in stretches of changing character
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:   result_stall <= 1'b0;
      STALL_THIRD:  result_stall <= (stall_tick % 3 == 0);
      STALL_RANDOM: result_stall <= 1'($urandom_range(0, 1));
      default:      result_stall <= (stall_tick % 8) < 6;
    endcase
  end

  // Offer one item, in bursts with random gaps, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk);
      text_valid <= 1'b0;
    end
    @(negedge clk);
    text_valid <= 1'b1;
    text_byte <= b;
    do @(posedge clk); while (!(text_valid && !text_stall));
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i]);
    texts_sent++;
  endtask

  // Drop valid and wait for the block to run dry
  task automatic settle();
    @(negedge clk);
    text_valid <= 1'b0;
    while (predicted_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  // Unused upper bits of the narrow registers carry noise
  task automatic apply_settings(input logic [63:0] chars, input int len, input int cap);
    logic [63:0] word;
    write_reg(CFG_LABEL_CHARS, chars);
    word = {$urandom, $urandom};
    word[3:0] = 4'(len);
    write_reg(CFG_LABEL_LENGTH, word);
    word = {$urandom, $urandom};
    word[8:0] = 9'(cap);
    write_reg(CFG_VALUE_CAPACITY, word);
    @(negedge clk);
    cfg_write <= 1'b0;
    gen_label = chars;
    gen_len = (len > LABEL_MAX) ? LABEL_MAX : len;
    settings_used++;
  endtask

  function automatic logic [63:0] pack_label(input string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < LABEL_MAX; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    if ($urandom_range(0, 1) == 0) return c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + CASE_GAP;
    if (c >= CH_UPPER_A + CASE_GAP && c <= CH_UPPER_Z + CASE_GAP) return c - CASE_GAP;
    return c;
  endfunction

  function automatic logic [7:0] rand_letter();
    return rand_case(CH_UPPER_A + 8'($urandom_range(0, 25)));
  endfunction

  task automatic push_eol();
    case ($urandom_range(0, 2))
      0: text_buf.push_back(CH_LF);
      1: text_buf.push_back(CH_CR);
      default: begin
        text_buf.push_back(CH_CR);
        text_buf.push_back(CH_LF);
      end
    endcase
  endtask

  task automatic push_noise_line();
    repeat ($urandom_range(0, 6)) text_buf.push_back(8'($urandom_range(1, 255)));
    push_eol();
  endtask

  // Mostly a label line with random spacing and value; some broken or noise only
  task automatic build_random_text();
    int kind, n, cut;
    logic [7:0] blanks [4];
    blanks = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
    text_buf.delete();
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(0, 2)) push_noise_line();
    if (kind < 9) begin
      n = (gen_len == 0) ? $urandom_range(1, 3) : gen_len;
      cut = n;
      if (kind == 8) begin
        if ($urandom_range(0, 1) == 0) text_buf.push_back(8'($urandom_range(1, 255)));
        else cut = $urandom_range(0, n - 1);
      end
      for (int i = 0; i < cut; i++) text_buf.push_back(rand_case(gen_label[8*i +: 8]));
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(0, 5))
          0: text_buf.push_back(CH_LF);
          1: text_buf.push_back(CH_CR);
          default: text_buf.push_back(blanks[$urandom_range(0, 3)]);
        endcase
      end
      if ($urandom_range(0, 9) < 7) text_buf.push_back(CH_COLON);
      repeat ($urandom_range(0, 2)) text_buf.push_back(blanks[$urandom_range(0, 1)]);
      repeat ($urandom_range(0, 12)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: text_buf.push_back(rand_letter());
          5, 6: text_buf.push_back(blanks[$urandom_range(0, 3)]);
          7: text_buf.push_back(8'($urandom_range(33, 126)));
          default: text_buf.push_back(8'($urandom_range(1, 255)));
        endcase
      end
      if ($urandom_range(0, 4) < 3) begin
        push_eol();
        if ($urandom_range(0, 1) == 0) push_noise_line();
      end
    end
    text_buf.push_back(CH_NUL);
  endtask

  initial begin : stimulus
    text_case_t tc;
    logic [63:0] lbl;
    int len, cap, random_bytes;

    // Hand-picked texts; rows with a typed value are checked against it
    text_cases.push_back('{0, "", 0, 0, "Host: a", 1, "", 0});
    text_cases.push_back('{1, "Host", 4, 64, "host: Example.COM", 1, "example.com", 1});
    text_cases.push_back('{1, "HOST", 4, 64, "x\nHoSt:\t A  B \r\nzz", 0, "", 0});
    text_cases.push_back('{1, "Host", 0, 64, "Host: a", 1, "", 0});
    text_cases.push_back('{1, "ABCDEFGH", 15, 64, "abcdefgh:v W", 0, "", 0});
    text_cases.push_back('{1, "k", 1, 0, "k: value", 1, "", 0});
    text_cases.push_back('{1, "k", 1, 1, "k: value", 1, "", 0});
    text_cases.push_back('{1, "k", 1, 2, "k:abc", 0, "", 0});
    text_cases.push_back('{1, "k", 1, 511, "k: \377\200Zz~", 0, "", 0});
    text_cases.push_back('{1, "K", 1, 256, "K\t\n :  x\014y\013z", 0, "", 0});
    text_cases.push_back('{1, "k", 1, 4, "k: ab  cd", 0, "", 0});
    text_cases.push_back('{1, "k", 1, 64, "k:   ", 0, "", 0});
    text_cases.push_back('{1, "k", 1, 64, "xk: a\nk: b", 0, "", 0});
    text_cases.push_back('{1, "\rk", 2, 64, "a\n\rk:v", 0, "", 0});
    text_cases.push_back('{1, "k", 2, 64, "k: a\nk", 1, "", 0});
    text_cases.push_back('{1, "k", 1, 64, "k:v\nk:w", 0, "", 0});
    text_cases.push_back('{1, "k", 1, 64, "k::x", 0, "", 0});
    text_cases.push_back('{1, "k", 1, 64, "kk:v", 0, "", 0});
    text_cases.push_back('{1, "k", 1, 64, "", 1, "", 0});
    text_cases.push_back('{1, "Ab", 2, 3, "\r\naB:\tz y", 0, "", 0});
    text_cases.push_back('{1, "k", 1, 257, "a\rk:q", 0, "", 0});

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the table
    foreach (text_cases[r]) begin
      tc = text_cases[r];
      if (tc.set_regs) apply_settings(pack_label(tc.label), tc.len, tc.cap);
      if (tc.typed) begin
        for (int i = 0; i < tc.value.len(); i++) begin
          predicted_values.push_back('{ch: tc.value[i], is_done: 1'b0, is_found: 1'b0});
        end
        predicted_values.push_back('{ch: CH_NUL, is_done: 1'b1, is_found: tc.hit});
        table_mode = 1'b1;
      end
      text_buf.delete();
      for (int i = 0; i < tc.text.len(); i++) text_buf.push_back(tc.text[i]);
      text_buf.push_back(CH_NUL);
      send_text();
      settle();
      table_mode = 1'b0;
    end

    // Random texts, with new settings now and then
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      if (random_bytes == 0 || $urandom_range(0, 2) == 0) begin
        settle();
        for (int i = 0; i < LABEL_MAX; i++) begin
          case ($urandom_range(0, 9))
            0: lbl[8*i +: 8] = 8'($urandom_range(33, 126));
            1: lbl[8*i +: 8] = 8'($urandom_range(1, 255));
            default: lbl[8*i +: 8] = rand_letter();
          endcase
        end
        case ($urandom_range(0, 19))
          0: len = 0;
          1: len = $urandom_range(9, 15);
          default: len = $urandom_range(1, LABEL_MAX);
        endcase
        case ($urandom_range(0, 9))
          6: cap = $urandom_range(13, 64);
          7: cap = $urandom_range(0, 1);
          8: cap = CAP_MAX;
          9: cap = $urandom_range(CAP_MAX + 1, 511);
          default: cap = $urandom_range(2, 12);
        endcase
        apply_settings(lbl, len, cap);
      end
      build_random_text();
      random_bytes += text_buf.size();
      send_text();
    end
    settle();

    $display("Sent %0d texts (%0d bytes) under %0d register settings; %0d results checked.",
             texts_sent, bytes_in, settings_used, results_checked);
    $display("Done items: %0d with a value, %0d without.", values_found, values_empty);
    if (errors == 0 && predicted_values.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
